// File: rtl/core/sl_pkg.sv
// ----------------------------------------------------------------------------
// sl_pkg: shared types and constants of the source lexer
// Token kinds, scan modes and the keyword table.
// ----------------------------------------------------------------------------
package sl_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int MAX_KW_LEN_DEF = 6;
    localparam int FIELD_WIDTH = 16;
    localparam int KIND_WIDTH = 6;
    localparam int NUM_KW = 12;

    localparam logic [KIND_WIDTH-1:0] K_SLASH      = 6'd10;
    localparam logic [KIND_WIDTH-1:0] K_BANG       = 6'd11;
    localparam logic [KIND_WIDTH-1:0] K_EQUAL      = 6'd13;
    localparam logic [KIND_WIDTH-1:0] K_GREATER    = 6'd15;
    localparam logic [KIND_WIDTH-1:0] K_LESS       = 6'd17;
    localparam logic [KIND_WIDTH-1:0] K_IDENT      = 6'd19;
    localparam logic [KIND_WIDTH-1:0] K_STRING     = 6'd20;
    localparam logic [KIND_WIDTH-1:0] K_INT        = 6'd21;
    localparam logic [KIND_WIDTH-1:0] K_KW_BASE    = 6'd22;
    localparam logic [KIND_WIDTH-1:0] K_EOF        = 6'd34;
    localparam logic [KIND_WIDTH-1:0] K_ERR_CHAR   = 6'd35;
    localparam logic [KIND_WIDTH-1:0] K_ERR_STRING = 6'd36;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_BANG    = 4'd1,
        M_EQUAL   = 4'd2,
        M_LESS    = 4'd3,
        M_GREATER = 4'd4,
        M_SLASH   = 4'd5,
        M_COMMENT = 4'd6,
        M_STRING  = 4'd7,
        M_NUMBER  = 4'd8,
        M_IDENT   = 4'd9
    } mode_t;

    // one token as it leaves the scanner
    typedef struct packed {
        logic [KIND_WIDTH-1:0]  kind;
        logic [FIELD_WIDTH-1:0] start_pos;
        logic [FIELD_WIDTH-1:0] end_pos;
        logic [FIELD_WIDTH-1:0] line_number;
    } token_t;

    // keyword text, first character in the low byte, zero padded to 8 bytes
    function automatic logic [63:0] kw_text(input logic [3:0] idx);
        logic [63:0] t;
        t = '0;
        unique case (idx)
            4'd0:    t = 64'h646e61;
            4'd1:    t = 64'h6669;
            4'd2:    t = 64'h65736c65;
            4'd3:    t = 64'h726f66;
            4'd4:    t = 64'h65736c6166;
            4'd5:    t = 64'h65757274;
            4'd6:    t = 64'h6c696e;
            4'd7:    t = 64'h6e7566;
            4'd8:    t = 64'h746e697270;
            4'd9:    t = 64'h726f;
            4'd10:   t = 64'h6e7275746572;
            4'd11:   t = 64'h6c6f6f62;
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] idx);
        logic [3:0] l;
        unique case (idx)
            4'd1, 4'd9:                   l = 4'd2;
            4'd0, 4'd3, 4'd6, 4'd7:       l = 4'd3;
            4'd2, 4'd5, 4'd11:            l = 4'd4;
            4'd4, 4'd8:                   l = 4'd5;
            4'd10:                        l = 4'd6;
            default:                      l = 4'd15;
        endcase
        return l;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

endpackage

// File: rtl/core/sl_stream_if.sv
// ----------------------------------------------------------------------------
// sl_stream_if: valid/ready channel
// Carries one payload of parameter type between a source and a sink.
// ----------------------------------------------------------------------------
interface sl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sl_kw_match.sv
// ----------------------------------------------------------------------------
// sl_kw_match: keyword lookup
// Compares the identifier buffer against the twelve keywords in parallel.
// ----------------------------------------------------------------------------
module sl_kw_match #(
    parameter int MAX_KW_LEN = sl_pkg::MAX_KW_LEN_DEF,
    localparam int LEN_W = $clog2(MAX_KW_LEN + 2)
) (
    input  logic [MAX_KW_LEN*8-1:0]          buffer,
    input  logic [LEN_W-1:0]                 length,
    output logic [sl_pkg::KIND_WIDTH-1:0]    kind
);
    logic [sl_pkg::NUM_KW-1:0] hit;

    always_comb
    begin
        logic [63:0] txt;
        logic [63:0] buf64;
        logic [63:0] mask;
        buf64 = '0;
        buf64[MAX_KW_LEN*8-1:0] = buffer;
        for (int k = 0; k < sl_pkg::NUM_KW; k++)
        begin
            txt = sl_pkg::kw_text(4'(k));
            mask = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (4'(b) < sl_pkg::kw_len(4'(k)))
                begin
                    mask[b*8 +: 8] = 8'hff;
                end
            end
            hit[k] = (32'(length) == 32'(sl_pkg::kw_len(4'(k))))
                && ((buf64 & mask) == txt);
        end
    end

    always_comb
    begin
        kind = sl_pkg::K_IDENT;
        for (int k = sl_pkg::NUM_KW - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                kind = sl_pkg::K_KW_BASE + sl_pkg::KIND_WIDTH'(k);
            end
        end
    end
endmodule

// File: rtl/core/sl_scan.sv
// ----------------------------------------------------------------------------
// sl_scan: scanner state machine
// Takes a request, updates the scan state and produces up to two
// tokens for it in the same cycle.
// ----------------------------------------------------------------------------
module sl_scan #(
    parameter int POS_WIDTH  = sl_pkg::POS_WIDTH_DEF,
    parameter int MAX_KW_LEN = sl_pkg::MAX_KW_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    char_byte,
    input  logic          end_of_input,
    output logic [1:0]    count,
    output sl_pkg::token_t tok0,
    output sl_pkg::token_t tok1
);
    localparam int LEN_W = $clog2(MAX_KW_LEN + 2);
    localparam int IDX_W = $clog2(MAX_KW_LEN);
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [15:0] LINE_MAX = 16'hffff;

    sl_pkg::mode_t          mode_reg, mode_next;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next;
    logic [POS_WIDTH-1:0]   start_reg, start_next;
    logic [15:0]            line_reg, line_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [7:0]             kw_buf_reg [MAX_KW_LEN];
    logic                   buf_we;
    logic [IDX_W-1:0]       buf_idx;
    logic [MAX_KW_LEN*8-1:0] buf_flat;
    logic [sl_pkg::KIND_WIDTH-1:0] id_kind;

    always_comb
    begin
        for (int i = 0; i < MAX_KW_LEN; i++)
        begin
            buf_flat[i*8 +: 8] = kw_buf_reg[i];
        end
    end

    sl_kw_match #(.MAX_KW_LEN(MAX_KW_LEN)) u_kw (
        .buffer (buf_flat),
        .length (len_reg),
        .kind   (id_kind)
    );

    function automatic logic [POS_WIDTH-1:0] inc(input logic [POS_WIDTH-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic logic [15:0] fld(input logic [POS_WIDTH-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[15:0];
    endfunction

    function automatic logic [sl_pkg::KIND_WIDTH-1:0] single_kind(input sl_pkg::mode_t m);
        logic [sl_pkg::KIND_WIDTH-1:0] k;
        unique case (m)
            sl_pkg::M_BANG:    k = sl_pkg::K_BANG;
            sl_pkg::M_EQUAL:   k = sl_pkg::K_EQUAL;
            sl_pkg::M_LESS:    k = sl_pkg::K_LESS;
            sl_pkg::M_GREATER: k = sl_pkg::K_GREATER;
            default:           k = sl_pkg::K_SLASH;
        endcase
        return k;
    endfunction

    always_comb
    begin
        sl_pkg::token_t t;
        logic [1:0] n;
        logic pass_on;
        logic flush;
        logic [15:0] line_v;
        logic [sl_pkg::KIND_WIDTH-1:0] pk;
        logic [POS_WIDTH-1:0] p;

        p = pos_reg;
        mode_next = mode_reg;
        start_next = start_reg;
        line_v = line_reg;
        len_next = len_reg;
        pos_next = inc(p);
        buf_we = 1'b0;
        buf_idx = '0;
        tok0 = '0;
        tok1 = '0;
        n = 2'd0;
        pass_on = 1'b1;
        flush = 1'b0;

        if (end_of_input)
        begin
            flush = 1'b1;
            pass_on = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                sl_pkg::M_BANG, sl_pkg::M_EQUAL, sl_pkg::M_LESS, sl_pkg::M_GREATER:
                begin
                    if (char_byte == "=")
                    begin
                        t.kind = single_kind(mode_reg) + 1'b1;
                        t.start_pos = fld(start_reg);
                        t.end_pos = fld(inc(p));
                        t.line_number = line_v;
                        tok0 = t;
                        n = 2'd1;
                        mode_next = sl_pkg::M_IDLE;
                        pass_on = 1'b0;
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                sl_pkg::M_SLASH:
                begin
                    if (char_byte == "/")
                    begin
                        mode_next = sl_pkg::M_COMMENT;
                        pass_on = 1'b0;
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                sl_pkg::M_COMMENT:
                begin
                    if (char_byte == 8'h0a)
                    begin
                        mode_next = sl_pkg::M_IDLE;
                    end
                    else
                    begin
                        pass_on = 1'b0;
                    end
                end
                sl_pkg::M_STRING:
                begin
                    if (char_byte == 8'h22)
                    begin
                        t.kind = sl_pkg::K_STRING;
                        t.start_pos = fld(start_reg);
                        t.end_pos = fld(inc(p));
                        t.line_number = line_v;
                        tok0 = t;
                        n = 2'd1;
                        mode_next = sl_pkg::M_IDLE;
                    end
                    else if (char_byte == 8'h0a && line_v != LINE_MAX)
                    begin
                        line_v = line_v + 1'b1;
                    end
                    pass_on = 1'b0;
                end
                sl_pkg::M_NUMBER:
                begin
                    if (sl_pkg::is_digit(char_byte))
                    begin
                        pass_on = 1'b0;
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                sl_pkg::M_IDENT:
                begin
                    if (sl_pkg::is_digit(char_byte) || sl_pkg::is_alpha(char_byte))
                    begin
                        if (32'(len_reg) < MAX_KW_LEN)
                        begin
                            buf_we = 1'b1;
                            buf_idx = IDX_W'(len_reg);
                        end
                        if (32'(len_reg) <= MAX_KW_LEN)
                        begin
                            len_next = len_reg + 1'b1;
                        end
                        pass_on = 1'b0;
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = sl_pkg::M_IDLE;
                end
            endcase
        end

        // pending token ends at the current position; a pending operator ends one past its start
        if (flush)
        begin
            pk = sl_pkg::K_IDENT;
            t.start_pos = fld(start_reg);
            t.end_pos = fld(p);
            t.line_number = line_v;
            unique case (mode_reg)
                sl_pkg::M_BANG, sl_pkg::M_EQUAL, sl_pkg::M_LESS, sl_pkg::M_GREATER,
                sl_pkg::M_SLASH:
                begin
                    pk = single_kind(mode_reg);
                    t.end_pos = fld(inc(start_reg));
                end
                sl_pkg::M_STRING: pk = sl_pkg::K_ERR_STRING;
                sl_pkg::M_NUMBER: pk = sl_pkg::K_INT;
                sl_pkg::M_IDENT:  pk = id_kind;
                default:          pk = sl_pkg::K_IDENT;
            endcase
            t.kind = pk;
            if (mode_reg != sl_pkg::M_IDLE && mode_reg != sl_pkg::M_COMMENT)
            begin
                tok0 = t;
                n = 2'd1;
            end
            mode_next = sl_pkg::M_IDLE;
        end

        if (pass_on)
        begin
            start_next = p;
            t.start_pos = fld(p);
            t.end_pos = fld(inc(p));
            t.line_number = line_v;
            t.kind = sl_pkg::K_ERR_CHAR;
            unique case (char_byte)
                "(": t.kind = 6'd0;
                ")": t.kind = 6'd1;
                "{": t.kind = 6'd2;
                "}": t.kind = 6'd3;
                ",": t.kind = 6'd4;
                ".": t.kind = 6'd5;
                "-": t.kind = 6'd6;
                "+": t.kind = 6'd7;
                ";": t.kind = 6'd8;
                "*": t.kind = 6'd9;
                default: t.kind = sl_pkg::K_ERR_CHAR;
            endcase
            priority case (1'b1)
                char_byte == "!":  mode_next = sl_pkg::M_BANG;
                char_byte == "=":  mode_next = sl_pkg::M_EQUAL;
                char_byte == "<":  mode_next = sl_pkg::M_LESS;
                char_byte == ">":  mode_next = sl_pkg::M_GREATER;
                char_byte == "/":  mode_next = sl_pkg::M_SLASH;
                char_byte == 8'h22: mode_next = sl_pkg::M_STRING;
                default: ;
            endcase
            if (char_byte == 8'h0a && line_v != LINE_MAX)
            begin
                line_v = line_v + 1'b1;
            end
            if (sl_pkg::is_digit(char_byte))
            begin
                mode_next = sl_pkg::M_NUMBER;
            end
            else if (sl_pkg::is_alpha(char_byte))
            begin
                mode_next = sl_pkg::M_IDENT;
                buf_we = 1'b1;
                buf_idx = '0;
                len_next = LEN_W'(1);
            end
            else if (t.kind != sl_pkg::K_ERR_CHAR || !(char_byte == "!" || char_byte == "="
                || char_byte == "<" || char_byte == ">" || char_byte == "/"
                || char_byte == 8'h22 || char_byte == 8'h20 || char_byte == 8'h0d
                || char_byte == 8'h09 || char_byte == 8'h0a))
            begin
                t.line_number = line_v;
                if (n == 2'd0)
                begin
                    tok0 = t;
                end
                else
                begin
                    tok1 = t;
                end
                n = n + 1'b1;
            end
        end

        if (end_of_input)
        begin
            t.kind = sl_pkg::K_EOF;
            t.start_pos = fld(p);
            t.end_pos = fld(p);
            t.line_number = line_v;
            if (n == 2'd0)
            begin
                tok0 = t;
            end
            else
            begin
                tok1 = t;
            end
            n = n + 1'b1;
            mode_next = sl_pkg::M_IDLE;
            pos_next = '0;
            start_next = '0;
            line_v = 16'd1;
            len_next = '0;
        end

        line_next = line_v;
        count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sl_pkg::M_IDLE;
            pos_reg <= '0;
            start_reg <= '0;
            line_reg <= 16'd1;
            len_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            start_reg <= start_next;
            line_reg <= line_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && buf_we)
        begin
            kw_buf_reg[buf_idx] <= char_byte;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_input |=> mode_reg == sl_pkg::M_IDLE && pos_reg == '0
            && line_reg == 16'd1)
        else $error("end of input did not clear scanner state");
    assert property (@(posedge clk) disable iff (!rst_n)
        step |-> count != 2'd0 || !end_of_input)
        else $error("end of input produced no token");
    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 16'd0)
        else $error("line count reached zero");
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= MAX_KW_LEN + 1)
        else $error("identifier length beyond saturation");
endmodule

// File: rtl/core/source_lexer_core.sv
// ----------------------------------------------------------------------------
// source_lexer_core: streaming source scanner
// One byte per request in, tokens with kind, offsets and line number out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | handshake
//  in_ch   | in  | char_byte, end_of_input                   | valid/ready
//  out_ch  | out | token_kind, start_pos, end_pos,           | valid/ready
//          |     | line_number, last                         |
//
//  One request per cycle when the output drains: the scanner state update and
//  the keyword compare are combinational between the input handshake and the
//  two-entry result register; tokens leave from the cycle after acceptance.
//  A request giving two tokens holds the input until its second token leaves.
//  Reset clears scan state, position 0, line 1.
//  Output stalls hold results in the result register and deassert in_ch.ready.
// ----------------------------------------------------------------------------
module source_lexer_core #(
    parameter int POS_WIDTH  = sl_pkg::POS_WIDTH_DEF,
    parameter int MAX_KW_LEN = sl_pkg::MAX_KW_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    sl_stream_if.sink   in_ch,
    sl_stream_if.source out_ch
);
    // result slots: two tokens; the last flag is derived from the count
    sl_pkg::token_t slot_reg [2];
    logic [1:0]     cnt_reg, cnt_next;
    logic           head_reg, head_next;
    logic           step;
    logic [1:0]     count;
    sl_pkg::token_t tok0, tok1;
    logic           pop;

    sl_scan #(.POS_WIDTH(POS_WIDTH), .MAX_KW_LEN(MAX_KW_LEN)) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_byte    (in_ch.data.char_byte),
        .end_of_input (in_ch.data.end_of_input),
        .count        (count),
        .tok0         (tok0),
        .tok1         (tok1)
    );

    assign pop = out_ch.valid && out_ch.ready;
    // accept when slots will be empty after this cycle's pop
    assign in_ch.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign step = in_ch.valid && in_ch.ready;

    assign out_ch.valid = cnt_reg != 2'd0;
    assign out_ch.data.token_kind = slot_reg[head_reg].kind;
    assign out_ch.data.start_pos = slot_reg[head_reg].start_pos;
    assign out_ch.data.end_pos = slot_reg[head_reg].end_pos;
    assign out_ch.data.line_number = slot_reg[head_reg].line_number;
    assign out_ch.data.last = cnt_reg == 2'd1;

    always_comb
    begin
        cnt_next = cnt_reg - {1'b0, pop};
        head_next = pop ? ~head_reg : head_reg;
        if (step)
        begin
            cnt_next = count;
            head_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            slot_reg[0] <= tok0;
            slot_reg[1] <= tok1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        step |-> cnt_reg == 2'd0 || pop)
        else $error("request accepted over pending results");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> head_reg == 1'b0)
        else $error("head moved before first result left");
endmodule
